[hdl/trld_pkg.sv]
// Shared types and constants for the Targa run-length scanline decoder.
`timescale 1ns / 1ps

package trld_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PixelW  = 32;
  localparam int unsigned CountW  = 2;
  localparam int unsigned WidthW  = 16;
  localparam int unsigned PosW    = 17;
  localparam int unsigned LeftW   = 8;
  localparam int unsigned BppW    = 3;
  localparam int unsigned BidxW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  // header byte layout
  localparam int unsigned RunBit = 7;
  localparam logic [ByteW-1:0] LenMask = 8'h7F;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBytesPerPixel = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLineWidth     = 2'd1;

  localparam logic [BppW-1:0]   BppReset   = 3'd1;
  localparam logic [WidthW-1:0] WidthReset = 16'd1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PIXEL   = 2'd1,
    PH_STOPPED = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PROC = 2'd1,
    ST_RUN  = 2'd2
  } state_e;

  typedef struct packed {
    logic [PixelW-1:0] pixel_a;
    logic [PixelW-1:0] pixel_b;
    logic [CountW-1:0] pixel_count;
    logic              last_of_run;
    logic              line_done;
    logic              overrun;
  } result_t;

  // 0 acts as 1, 5..7 act as 4
  function automatic logic [BppW-1:0] clamp_bpp(input logic [BppW-1:0] raw);
    logic [BppW-1:0] r;
    r = raw;
    if (raw == 3'd0) begin
      r = 3'd1;
    end else if (raw > 3'd4) begin
      r = 3'd4;
    end
    return r;
  endfunction

endpackage

[hdl/tga_rle_line_decoder.sv]
// Top level of the Targa run-length scanline decoder.
`timescale 1ns / 1ps

// Takes one compressed byte per request and returns decoded pixels; a request
// is accepted and then decoded, with the input stalled until decoding ends, and
// a byte that completes a run pixel holds the input while the run is emitted,
// one result per cycle with the run length n from 1 to 128, unless the output
// side stalls. One 18-bit adder and compare against line_width, shared by the
// header check, literal pixels and each step of the run loop, sets that pace.
// A result waits in an output register, so the next byte is taken while it is
// still pending. Configuration writes are always ready and must be made while
// no byte is in flight. After a byte marked end_of_buffer the line state is
// cleared for the next scanline.
module tga_rle_line_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [trld_pkg::ByteW-1:0]     data_byte_i,
  input  logic                           end_of_buffer_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [trld_pkg::PixelW-1:0]    pixel_a_o,
  output logic [trld_pkg::PixelW-1:0]    pixel_b_o,
  output logic [trld_pkg::CountW-1:0]    pixel_count_o,
  output logic                           last_of_run_o,
  output logic                           line_done_o,
  output logic                           overrun_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [trld_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [trld_pkg::CfgDatW-1:0]   cfg_data_i
);

  trld_pkg::state_e state_q, state_d;
  trld_pkg::phase_e phase_q, phase_d;

  logic [trld_pkg::LeftW-1:0]  left_q, left_d;
  logic                        run_q, run_d;
  logic [trld_pkg::BidxW-1:0]  bidx_q, bidx_d;
  logic [trld_pkg::PixelW-1:0] gather_q, gather_d;
  logic [trld_pkg::PixelW-1:0] px_q, px_d;
  logic [trld_pkg::PosW-1:0]   pos_q, pos_d;
  logic [trld_pkg::ByteW-1:0]  byte_q;
  logic                        eob_q;
  logic [trld_pkg::BppW-1:0]   bpp_q;
  logic [trld_pkg::WidthW-1:0] lw_q;

  trld_pkg::result_t res_q, res_d;
  logic              out_valid_q, out_valid_d;

  logic in_acc, out_free;

  // shared adder / comparator
  logic [trld_pkg::LeftW-1:0] addend;
  logic [trld_pkg::PosW:0]    sum;
  logic                       sum_gt, sum_ge, pos_ge;

  // decode of the held byte
  logic [trld_pkg::LeftW-1:0]  hdr_cnt;
  logic [trld_pkg::BppW-1:0]   size;
  logic [trld_pkg::PixelW-1:0] gather_new;
  logic                        px_complete;
  logic [trld_pkg::LeftW-1:0]  take;
  logic [trld_pkg::LeftW-1:0]  left_after;
  logic                        finish;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != trld_pkg::ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign hdr_cnt     = (byte_q & trld_pkg::LenMask) + 8'd1;
  assign size        = trld_pkg::clamp_bpp(bpp_q);
  assign gather_new  = gather_q | ({24'd0, byte_q} << {bidx_q, 3'b000});
  assign px_complete = ({1'b0, bidx_q} + 3'd1) >= size;
  assign take        = (left_q >= 8'd2) ? 8'd2 : left_q;

  always_comb begin
    addend = 8'd1;
    if (state_q == trld_pkg::ST_RUN) begin
      addend = take;
    end else if (phase_q == trld_pkg::PH_HEADER) begin
      addend = hdr_cnt;
    end
  end

  assign sum    = {1'b0, pos_q} + {10'd0, addend};
  assign sum_gt = sum > {2'b00, lw_q};
  assign sum_ge = sum >= {2'b00, lw_q};
  assign pos_ge = pos_q >= {1'b0, lw_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      trld_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = trld_pkg::ST_PROC;
        end
      end
      trld_pkg::ST_PROC: begin
        if (phase_q == trld_pkg::PH_PIXEL && px_complete && run_q) begin
          state_d = trld_pkg::ST_RUN;
        end else if (finish) begin
          state_d = trld_pkg::ST_IDLE;
        end
      end
      trld_pkg::ST_RUN: begin
        if (finish) begin
          state_d = trld_pkg::ST_IDLE;
        end
      end
      default: state_d = trld_pkg::ST_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    phase_d     = phase_q;
    left_d      = left_q;
    run_d       = run_q;
    bidx_d      = bidx_q;
    gather_d    = gather_q;
    px_d        = px_q;
    pos_d       = pos_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    finish      = 1'b0;
    left_after  = left_q - take;

    case (state_q)
      trld_pkg::ST_PROC: begin
        case (phase_q)
          trld_pkg::PH_HEADER: begin
            if (pos_ge) begin
              phase_d = trld_pkg::PH_STOPPED;
              finish  = 1'b1;
            end else if (sum_gt) begin
              if (out_free) begin
                res_d       = '0;
                res_d.last_of_run = 1'b1;
                res_d.overrun     = 1'b1;
                out_valid_d = 1'b1;
                phase_d     = trld_pkg::PH_STOPPED;
                finish      = 1'b1;
              end
            end else begin
              run_d    = byte_q[trld_pkg::RunBit];
              left_d   = hdr_cnt;
              bidx_d   = '0;
              gather_d = '0;
              phase_d  = trld_pkg::PH_PIXEL;
              finish   = 1'b1;
            end
          end
          trld_pkg::PH_PIXEL: begin
            if (!px_complete) begin
              gather_d = gather_new;
              bidx_d   = bidx_q + 2'd1;
              finish   = 1'b1;
            end else if (run_q) begin
              px_d     = gather_new;
              gather_d = '0;
              bidx_d   = '0;
            end else if (out_free) begin
              gather_d = '0;
              bidx_d   = '0;
              pos_d    = sum[trld_pkg::PosW-1:0];
              left_d   = left_q - 8'd1;
              res_d.pixel_a     = gather_new;
              res_d.pixel_b     = '0;
              res_d.pixel_count = 2'd1;
              res_d.last_of_run = 1'b1;
              res_d.line_done   = sum_ge;
              res_d.overrun     = 1'b0;
              out_valid_d       = 1'b1;
              if (sum_ge) begin
                phase_d = trld_pkg::PH_STOPPED;
              end else if (left_q == 8'd1) begin
                phase_d = trld_pkg::PH_HEADER;
              end
              finish = 1'b1;
            end
          end
          default: finish = 1'b1;
        endcase
      end
      trld_pkg::ST_RUN: begin
        if (left_q == '0) begin
          // nothing left to emit
          phase_d = pos_ge ? trld_pkg::PH_STOPPED : trld_pkg::PH_HEADER;
          finish  = 1'b1;
        end else if (out_free) begin
          pos_d  = sum[trld_pkg::PosW-1:0];
          left_d = left_after;
          res_d.pixel_a     = px_q;
          res_d.pixel_b     = (take == 8'd2) ? px_q : '0;
          res_d.pixel_count = take[trld_pkg::CountW-1:0];
          res_d.last_of_run = (left_after == '0);
          res_d.line_done   = (left_after == '0) && sum_ge;
          res_d.overrun     = 1'b0;
          out_valid_d       = 1'b1;
          if (left_after == '0) begin
            phase_d = sum_ge ? trld_pkg::PH_STOPPED : trld_pkg::PH_HEADER;
            finish  = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // end of buffer: clear the line once the byte has been handled
    if (finish && eob_q) begin
      phase_d  = trld_pkg::PH_HEADER;
      left_d   = '0;
      run_d    = 1'b0;
      bidx_d   = '0;
      gather_d = '0;
      pos_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trld_pkg::ST_IDLE;
      phase_q     <= trld_pkg::PH_HEADER;
      left_q      <= '0;
      run_q       <= 1'b0;
      bidx_q      <= '0;
      gather_q    <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      bpp_q       <= trld_pkg::BppReset;
      lw_q        <= trld_pkg::WidthReset;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      left_q      <= left_d;
      run_q       <= run_d;
      bidx_q      <= bidx_d;
      gather_q    <= gather_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == trld_pkg::CfgBytesPerPixel) begin
          bpp_q <= cfg_data_i[trld_pkg::BppW-1:0];
        end else if (cfg_index_i == trld_pkg::CfgLineWidth) begin
          lw_q <= cfg_data_i;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    res_q <= res_d;
    if (in_acc) begin
      byte_q <= data_byte_i;
      eob_q  <= end_of_buffer_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_a_o     = res_q.pixel_a;
  assign pixel_b_o     = res_q.pixel_b;
  assign pixel_count_o = res_q.pixel_count;
  assign last_of_run_o = res_q.last_of_run;
  assign line_done_o   = res_q.line_done;
  assign overrun_o     = res_q.overrun;

endmodule

[hdl/trld_checker.sv]
// Port-level checks for the Targa run-length scanline decoder, bound to the top.
`timescale 1ns / 1ps

module trld_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [trld_pkg::PixelW-1:0]   pixel_a_o,
  input logic [trld_pkg::PixelW-1:0]   pixel_b_o,
  input logic [trld_pkg::CountW-1:0]   pixel_count_o,
  input logic                          last_of_run_o,
  input logic                          line_done_o,
  input logic                          overrun_o
);

  // an overrun carries no pixels and ends the byte's results
  a_overrun_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overrun_o |->
      pixel_count_o == 2'd0 && last_of_run_o && !line_done_o && pixel_a_o == '0)
    else $error("overrun result malformed");

  // pixel results carry one or two pixels
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !overrun_o |-> pixel_count_o == 2'd1 || pixel_count_o == 2'd2)
    else $error("bad pixel count");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_done_o |-> last_of_run_o)
    else $error("line done before last result");

  a_single_b_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_count_o == 2'd1 |-> pixel_b_o == '0)
    else $error("second pixel set on single-pixel result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_a_o) &&
      $stable(pixel_count_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

endmodule

bind tga_rle_line_decoder trld_checker u_trld_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .pixel_a_o    (pixel_a_o),
  .pixel_b_o    (pixel_b_o),
  .pixel_count_o(pixel_count_o),
  .last_of_run_o(last_of_run_o),
  .line_done_o  (line_done_o),
  .overrun_o    (overrun_o)
);

[test/tga_rle_line_decoder_test.sv]
// Self-checking testbench for the Targa run-length scanline decoder.
`timescale 1ns / 1ps

module tga_rle_line_decoder_test;
  import trld_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned RandomBytes = 300;

  // Predicts decoded pixels from accepted bytes and checks the block's results.
  class scanline_board;
    logic [BppW-1:0]   bpp;
    logic [WidthW-1:0] width;
    phase_e            phase;
    logic [LeftW-1:0]  left;
    logic              run;
    logic [BidxW-1:0]  bidx;
    logic [PixelW-1:0] gather;
    logic [PosW-1:0]   pos;
    result_t           due_pixels[$];
    int unsigned       mismatches;

    function new();
      bpp = BppReset;
      width = WidthReset;
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      phase = PH_HEADER;
      left = '0;
      run = 1'b0;
      bidx = '0;
      gather = '0;
      pos = '0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
      if (idx == CfgBytesPerPixel) begin
        bpp = data[BppW-1:0];
      end else if (idx == CfgLineWidth) begin
        width = data[WidthW-1:0];
      end
    endfunction

    function void push_pixels(logic [PixelW-1:0] a, logic [PixelW-1:0] b, int unsigned n,
                              logic last, logic done, logic ovr);
      result_t r;
      r.pixel_a = a;
      r.pixel_b = b;
      r.pixel_count = CountW'(n);
      r.last_of_run = last;
      r.line_done = done;
      r.overrun = ovr;
      due_pixels.push_back(r);
    endfunction

    function void take_byte(logic [ByteW-1:0] b, logic eob);
      int unsigned size;
      int unsigned cnt;
      int unsigned p;
      int unsigned want;
      int unsigned take;
      logic [PixelW-1:0] px;
      size = (bpp == 0) ? 1 : (bpp > 4) ? 4 : int'(bpp);
      case (phase)
        PH_HEADER: begin
          cnt = int'(b & LenMask) + 1;
          if (pos >= width) begin
            phase = PH_STOPPED;
          end else if (pos + cnt > width) begin
            push_pixels('0, '0, 0, 1'b1, 1'b0, 1'b1);
            phase = PH_STOPPED;
          end else begin
            run = b[RunBit];
            left = LeftW'(cnt);
            bidx = '0;
            gather = '0;
            phase = PH_PIXEL;
          end
        end
        PH_PIXEL: begin
          gather = gather | (PixelW'(b) << (8 * bidx));
          if (bidx + 1 >= size) begin
            px = gather;
            bidx = '0;
            gather = '0;
            p = pos;
            if (run) begin
              // two pixels per result, odd tail goes out alone
              want = left;
              while (want > 0) begin
                take = (want >= 2) ? 2 : want;
                want -= take;
                p += take;
                push_pixels(px, (take == 2) ? px : '0, take, want == 0,
                            (want == 0) && (p >= width), 1'b0);
              end
              left = '0;
            end else begin
              p += 1;
              left = left - 1'b1;
              push_pixels(px, '0, 1, 1'b1, p >= width, 1'b0);
            end
            pos = PosW'(p);
            if (pos >= width) begin
              phase = PH_STOPPED;
            end else if (left == 0) begin
              phase = PH_HEADER;
            end
          end else begin
            bidx = bidx + 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (eob) begin
        clear_line();
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 20) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
    endtask

    task check_pixels(result_t got);
      result_t want;
      if (due_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result a=%h b=%h count=%0d ovr=%b",
                                  got.pixel_a, got.pixel_b, got.pixel_count, got.overrun));
        return;
      end
      want = due_pixels.pop_front();
      if (got.pixel_a !== want.pixel_a)
        report_mismatch($sformatf("pixel_a %h, want %h", got.pixel_a, want.pixel_a));
      if (got.pixel_b !== want.pixel_b)
        report_mismatch($sformatf("pixel_b %h, want %h", got.pixel_b, want.pixel_b));
      if (got.pixel_count !== want.pixel_count)
        report_mismatch($sformatf("pixel_count %0d, want %0d", got.pixel_count,
                                  want.pixel_count));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("last_of_run %b, want %b", got.last_of_run,
                                  want.last_of_run));
      if (got.line_done !== want.line_done)
        report_mismatch($sformatf("line_done %b, want %b", got.line_done, want.line_done));
      if (got.overrun !== want.overrun)
        report_mismatch($sformatf("overrun %b, want %b", got.overrun, want.overrun));
    endtask

    task flush_leftovers();
      foreach (due_pixels[i]) begin
        report_mismatch($sformatf("result never seen: a=%h count=%0d ovr=%b",
                                  due_pixels[i].pixel_a, due_pixels[i].pixel_count,
                                  due_pixels[i].overrun));
      end
      due_pixels.delete();
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [ByteW-1:0]    data_byte_i = '0;
  logic                end_of_buffer_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [PixelW-1:0]   pixel_a_o;
  logic [PixelW-1:0]   pixel_b_o;
  logic [CountW-1:0]   pixel_count_o;
  logic                last_of_run_o;
  logic                line_done_o;
  logic                overrun_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDatW-1:0]  cfg_data_i = '0;

  scanline_board       sb;
  logic [ByteW-1:0]    line_bytes[$];
  int unsigned         send_idle = 26;
  int unsigned         recv_idle = 62;
  int unsigned         bytes_sent = 0;
  int unsigned         hold_requests = 0;
  int unsigned         hold_seen = 0;
  int unsigned         hold_left = 0;
  int unsigned         cycle_count = 0;

  tga_rle_line_decoder uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .data_byte_i,
    .end_of_buffer_i,
    .out_valid_o,
    .out_stall_i,
    .pixel_a_o,
    .pixel_b_o,
    .pixel_count_o,
    .last_of_run_o,
    .line_done_o,
    .overrun_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tga_rle_line_decoder_test NOT OK");
      $finish;
    end
  end

  // result side: check, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_pixels({pixel_a_o, pixel_b_o, pixel_count_o, last_of_run_o, line_done_o,
                       overrun_o});
    end
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  task automatic send_byte(logic [ByteW-1:0] b, logic eob);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    end_of_buffer_i <= eob;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_byte(b, eob);
    bytes_sent++;
  endtask

  task automatic send_line(bit eob_last);
    foreach (line_bytes[i]) begin
      send_byte(line_bytes[i], eob_last && (i == line_bytes.size() - 1));
    end
  endtask

  task automatic set_register(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, data);
  endtask

  task automatic configure(logic [CfgDatW-1:0] bpp_data, logic [CfgDatW-1:0] width_data);
    set_register(CfgBytesPerPixel, bpp_data);
    set_register(CfgLineWidth, width_data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering, let every due result come out, then cover in-flight bytes
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.due_pixels.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // One scanline worth of packets, occasionally overrunning, noisy or cut short.
  function automatic void build_line(int unsigned size, int unsigned width);
    int unsigned placed;
    int unsigned cnt;
    int unsigned rem;
    int unsigned packets;
    bit          is_run;
    line_bytes.delete();
    placed = 0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) line_bytes.push_back(ByteW'($urandom));
      return;
    end
    packets = $urandom_range(1, 6);
    while (placed < width && packets > 0) begin
      packets--;
      is_run = $urandom_range(0, 1);
      rem = width - placed;
      if ($urandom_range(0, 11) == 0) begin
        cnt = $urandom_range(1, 128);
      end else if (is_run && $urandom_range(0, 3) == 0) begin
        cnt = $urandom_range(1, (rem < 128) ? rem : 128);
      end else begin
        cnt = $urandom_range(1, (rem < 6) ? rem : 6);
      end
      line_bytes.push_back({is_run, 7'(cnt - 1)});
      if (placed + cnt > width) break;
      repeat (is_run ? size : cnt * size) line_bytes.push_back(ByteW'($urandom));
      placed += cnt;
    end
    repeat ($urandom_range(0, 2)) line_bytes.push_back(ByteW'($urandom));
    if ($urandom_range(0, 7) == 0 && line_bytes.size() > 1) begin
      repeat ($urandom_range(1, line_bytes.size() - 1)) void'(line_bytes.pop_back());
    end
    if (line_bytes.size() == 0) line_bytes.push_back(ByteW'($urandom));
  endfunction

  initial begin
    int unsigned lines;
    int unsigned start_count;
    int unsigned size;
    logic [BppW-1:0]   bpp;
    logic [WidthW-1:0] width_val;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // run of 128, literal, overrun, ignored byte while stopped
    configure(16'd1, 16'd200);
    line_bytes = '{8'hFF, 8'hAB, 8'h00, 8'h5A, 8'h7F, 8'h12, 8'h00};
    send_line(1'b1);
    drain();
    // 4-byte pixels: paired run, then literal that fills the line
    configure(16'd4, 16'd3);
    line_bytes = '{8'h81, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04,
                   8'h55};
    send_line(1'b1);
    drain();
    // zero width: both bytes ignored; pixel size set to 0, which acts as 1
    configure(16'd0, 16'd0);
    line_bytes = '{8'h00, 8'h80};
    send_line(1'b1);
    drain();
    // pixel size 7 acts as 4; end of buffer on the completing byte
    configure(16'd7, 16'hFFFF);
    line_bytes = '{8'h80, 8'h11, 8'h22, 8'h33, 8'h44};
    send_line(1'b1);
    drain();

    hold_requests <= hold_requests + 1;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RandomBytes) begin
      if (bytes_sent - start_count < RandomBytes / 3) begin
        send_idle = 26;
        recv_idle = 62;
      end else if (bytes_sent - start_count < 2 * RandomBytes / 3) begin
        send_idle = 62;
        recv_idle = 26;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case ($urandom_range(0, 9))
        0:       bpp = 3'd0;
        1:       bpp = 3'($urandom_range(5, 7));
        default: bpp = 3'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 11))
        0:       width_val = 16'd0;
        1:       width_val = 16'hFFFF;
        2:       width_val = 16'($urandom);
        3:       width_val = 16'd1;
        default: width_val = 16'($urandom_range(1, 48));
      endcase
      configure({13'($urandom), bpp}, width_val);
      size = (bpp == 0) ? 1 : (bpp > 4) ? 4 : int'(bpp);
      lines = $urandom_range(2, 5);
      repeat (lines - 1) begin
        build_line(size, width_val);
        send_line(1'b1);
      end
      // sometimes leave the line open so the next setting lands mid-line
      build_line(size, width_val);
      send_line($urandom_range(0, 3) != 0);
      drain();
    end

    sb.flush_leftovers();
    if (sb.mismatches == 0) begin
      $display("tga_rle_line_decoder_test OK");
    end else begin
      $display("tga_rle_line_decoder_test NOT OK");
    end
    $finish;
  end

endmodule
